// ===== rtl/gcc_pkg.sv =====
package gcc_pkg;

    // Widths of the fixed fields and of the configuration port.
    localparam int FIELD_W       = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int COINS_USE_W   = 3;
    localparam int NUM_COIN_REGS = 4;

    // Defaults of the top-level parameters.
    localparam int DEFAULT_MAX_COINS   = 4;
    localparam int DEFAULT_AMOUNT_BITS = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_COINS_IN_USE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

    // Reset values of the registers.
    localparam logic [COINS_USE_W-1:0] COINS_IN_USE_RESET = 3'd4;
    localparam logic [FIELD_W-1:0]     COIN_VALUE_RESET   = 16'd1;

    // Control and status between the sequencer and the serial divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/gcc_cfg_regs.sv =====
module gcc_cfg_regs
    import gcc_pkg::*;
#(
    parameter int MAX_COINS = DEFAULT_MAX_COINS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output logic [COINS_USE_W-1:0] coins_in_use,
    output logic [FIELD_W-1:0]     coin_value [MAX_COINS]
);

    logic [COINS_USE_W-1:0] coins_in_use_reg;
    logic [FIELD_W-1:0]     coin_value_reg [MAX_COINS];

    // Register file. Slots without a register of their own keep the reset value,
    // and writes to unknown indexes fall through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coins_in_use_reg <= COINS_IN_USE_RESET;
            for (int s = 0; s < MAX_COINS; s++) begin
                coin_value_reg[s] <= COIN_VALUE_RESET;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_COINS_IN_USE) begin
                coins_in_use_reg <= cfg_wr_data[COINS_USE_W-1:0];
            end
            for (int s = 0; s < MAX_COINS; s++) begin
                if (s < NUM_COIN_REGS &&
                    cfg_index == CFG_INDEX_W'(int'(REG_COIN_VALUE_0) + s)) begin
                    coin_value_reg[s] <= cfg_wr_data[FIELD_W-1:0];
                end
            end
        end
    end

    assign coins_in_use = coins_in_use_reg;
    assign coin_value   = coin_value_reg;

endmodule

// ===== rtl/gcc_serial_div.sv =====
module gcc_serial_div
    import gcc_pkg::*;
#(
    parameter int AMOUNT_W = DEFAULT_AMOUNT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  div_ctrl_t           ctrl,
    input  logic [AMOUNT_W-1:0] dividend,
    input  logic [FIELD_W-1:0]  divisor,
    output div_stat_t           stat,
    output logic [AMOUNT_W-1:0] quotient,
    output logic [AMOUNT_W-1:0] remainder
);

    localparam int CNT_W = $clog2(AMOUNT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [AMOUNT_W-1:0] quo_reg, quo_next;
    logic [FIELD_W-1:0]  part_reg, part_next;

    logic [FIELD_W:0]    trial;
    logic [FIELD_W:0]    diff;
    logic                fits;

    // One restoring step: bring in the next dividend bit and try the subtract.
    assign trial = {part_reg, quo_reg[AMOUNT_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            part_next = '0;
        end else if (busy_reg) begin
            part_next = fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
            quo_next  = {quo_reg[AMOUNT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(AMOUNT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags are reset; the shift registers need no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        part_reg <= part_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg[AMOUNT_W-1:0];

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (part_reg < divisor))
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

// ===== rtl/greedy_coin_change_counter.sv =====
// Channel  | Direction | Ports                                   | Word
// ---------+-----------+-----------------------------------------+---------------------------
// s_       | in        | s_valid, s_ready, s_amount              | amount to pay out
// m_       | out       | m_valid, m_ready, m_coin_count, m_leftover | coin count and leftover
// cfg_     | in        | cfg_wr_en, cfg_index, cfg_wr_data       | register write, no wait
//
// Work: one round per coin in use (U), AW = min(AMOUNT_BITS, 16); each round is a scan of the U slots
// for the largest unused value, a decide step and a serial divide of AW quotient bits, or the
// scan and decide alone when the value does not fit. Reset is synchronous, active low, and
// restores the configuration registers and the control state. A finished result waits in
// the output register while the next word is worked; that word then holds until it is free.
module greedy_coin_change_counter
    import gcc_pkg::*;
#(
    parameter int MAX_COINS   = DEFAULT_MAX_COINS,
    parameter int AMOUNT_BITS = DEFAULT_AMOUNT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FIELD_W-1:0]     s_amount,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_W-1:0]     m_coin_count,
    output logic [FIELD_W-1:0]     m_leftover,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // The amount port is 16 bits, so the work never needs more than that.
    localparam int AW = (AMOUNT_BITS < FIELD_W) ? AMOUNT_BITS : FIELD_W;
    localparam int CW = $clog2(MAX_COINS + 1);
    localparam int IW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]     coin_count_reg, coin_count_next;
    logic [FIELD_W-1:0]     leftover_reg, leftover_next;
    logic [AW-1:0]          rem_reg, rem_next;
    logic [AW-1:0]          count_reg, count_next;
    logic [MAX_COINS-1:0]   done_mask_reg, done_mask_next;
    logic [CW-1:0]          round_reg, round_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [FIELD_W-1:0]     best_val_reg, best_val_next;
    logic                   found_reg, found_next;

    logic [COINS_USE_W-1:0] coins_in_use;
    logic [FIELD_W-1:0]     coin_value [MAX_COINS];
    logic [CW-1:0]          used;
    logic [CW-1:0]          last_slot;
    logic [IW-1:0]          scan_idx;
    logic [FIELD_W-1:0]     scan_val;

    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [AW-1:0]          div_quotient;
    logic [AW-1:0]          div_remainder;

    gcc_cfg_regs #(
        .MAX_COINS(MAX_COINS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .coins_in_use(coins_in_use),
        .coin_value  (coin_value)
    );

    gcc_serial_div #(
        .AMOUNT_W(AW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (rem_reg),
        .divisor  (best_val_reg),
        .stat     (div_stat),
        .quotient (div_quotient),
        .remainder(div_remainder)
    );

    // A count above the number of slots is treated as all slots.
    assign used      = (coins_in_use > COINS_USE_W'(MAX_COINS)) ? CW'(MAX_COINS)
                                                                : CW'(coins_in_use);
    assign last_slot = used - 1'b1;
    assign scan_idx  = scan_reg[IW-1:0];
    assign scan_val  = coin_value[scan_idx];

    // Sequencer: per round, scan for the largest unused denomination, then divide by it when it fits.
    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        coin_count_next = coin_count_reg;
        leftover_next   = leftover_reg;
        rem_next        = rem_reg;
        count_next      = count_reg;
        done_mask_next  = done_mask_reg;
        round_next      = round_reg;
        scan_next       = scan_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        found_next      = found_reg;
        div_ctrl.start  = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rem_next       = s_amount[AW-1:0];
                    count_next     = '0;
                    done_mask_next = '0;
                    round_next     = '0;
                    scan_next      = '0;
                    found_next     = 1'b0;
                    state_next     = (used == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!done_mask_reg[scan_idx] && (!found_reg || scan_val > best_val_reg)) begin
                    best_val_next = scan_val;
                    best_idx_next = scan_idx;
                    found_next    = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == last_slot) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                done_mask_next[best_idx_reg] = 1'b1;
                if (best_val_reg != '0 && best_val_reg <= FIELD_W'(rem_reg)) begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    round_next = round_reg + 1'b1;
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = (round_reg == last_slot) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    count_next = count_reg + div_quotient;
                    rem_next   = div_remainder;
                    round_next = round_reg + 1'b1;
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = (round_reg == last_slot) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    coin_count_next = FIELD_W'(count_reg);
                    leftover_next   = FIELD_W'(rem_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs; only control state is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        coin_count_reg <= coin_count_next;
        leftover_reg   <= leftover_next;
        rem_reg        <= rem_next;
        count_reg      <= count_next;
        done_mask_reg  <= done_mask_next;
        round_reg      <= round_next;
        scan_reg       <= scan_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        found_reg      <= found_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_coin_count = coin_count_reg;
    assign m_leftover   = leftover_reg;

`ifndef NO_ASSERTIONS
    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is still in work");

    a_rem_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |-> (rem_reg <= $past(rem_reg)))
        else $error("remaining amount grew during a word");

    a_divisor_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (best_val_reg != '0 && best_val_reg <= FIELD_W'(rem_reg)))
        else $error("division started with a denomination that does not fit");
`endif

endmodule

// ===== bench/tb_greedy_coin_change_counter.sv =====
`timescale 1ns / 100ps

module tb_greedy_coin_change_counter;
    import gcc_pkg::*;

    localparam int MAX_COINS    = DEFAULT_MAX_COINS;
    localparam int AMOUNT_BITS  = DEFAULT_AMOUNT_BITS;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_GAP      = 20;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 50;
    localparam int LIMIT_NS     = 4_000_000;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;

    // Register indexes beyond the package's first two.
    localparam cfg_idx_t REG_COIN_VALUE_1 = REG_COIN_VALUE_0 + 3'd1;
    localparam cfg_idx_t REG_COIN_VALUE_2 = REG_COIN_VALUE_0 + 3'd2;
    localparam cfg_idx_t REG_COIN_VALUE_3 = REG_COIN_VALUE_0 + 3'd3;
    localparam cfg_idx_t REG_SPARE_5      = 3'd5;
    localparam cfg_idx_t REG_SPARE_6      = 3'd6;
    localparam cfg_idx_t REG_SPARE_7      = 3'd7;

    typedef enum logic {
        ROW_WRITE,
        ROW_AMOUNT
    } row_kind_t;

    typedef struct packed {
        logic [FIELD_W-1:0] coin_count;
        logic [FIELD_W-1:0] leftover;
    } change_t;

    // One row of the directed part: a register write or an amount, with an
    // optional hand-typed result.
    typedef struct packed {
        row_kind_t          kind;
        cfg_idx_t           index;
        logic [FIELD_W-1:0] value;
        logic               typed;
        logic [FIELD_W-1:0] exp_count;
        logic [FIELD_W-1:0] exp_left;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 44;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Register values after reset: four coins of value 1.
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd0,     1'b1, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b1, 16'd65535, 16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd1,     1'b1, 16'd1,     16'd0},
        // Denominations written out of order.
        '{ROW_WRITE,  REG_COIN_VALUE_0, 16'd1,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_1, 16'd5,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_2, 16'd25,    1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_3, 16'd10,    1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd30,    1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd99,    1'b0, 16'd0,     16'd0},
        // No denomination in use: everything is left over.
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'h0000,  1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd1234,  1'b1, 16'd0,     16'd1234},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b1, 16'd0,     16'd65535},
        // Too many coins in use, clamped to the number of slots.
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'hFFFF,  1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd41,    1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd12345, 1'b0, 16'd0,     16'd0},
        // A zero denomination takes no part.
        '{ROW_WRITE,  REG_COIN_VALUE_3, 16'd0,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_0, 16'd7,     1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd100,   1'b0, 16'd0,     16'd0},
        // No coin of value 1, with high bits set in the count register.
        '{ROW_WRITE,  REG_COIN_VALUE_0, 16'd6,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_1, 16'd4,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'hFFFA,  1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd5,     1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd3,     1'b1, 16'd0,     16'd3},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b0, 16'd0,     16'd0},
        // Equal denominations.
        '{ROW_WRITE,  REG_COIN_VALUE_0, 16'd7,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_1, 16'd7,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_2, 16'd3,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COIN_VALUE_3, 16'd3,     1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'd4,     1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd23,    1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b0, 16'd0,     16'd0},
        // The largest denomination alone.
        '{ROW_WRITE,  REG_COIN_VALUE_0, 16'd65535, 1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'd1,     1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b1, 16'd1,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65534, 1'b1, 16'd0,     16'd65534},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd0,     1'b1, 16'd0,     16'd0},
        // Writes to unknown registers change nothing.
        '{ROW_WRITE,  REG_SPARE_5,      16'hFFFF,  1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_SPARE_6,      16'h0001,  1'b0, 16'd0,     16'd0},
        '{ROW_WRITE,  REG_SPARE_7,      16'hA5A5,  1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b1, 16'd1,     16'd0},
        // Three coins, one of them the largest value.
        '{ROW_WRITE,  REG_COINS_IN_USE, 16'd3,     1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd65535, 1'b0, 16'd0,     16'd0},
        '{ROW_AMOUNT, REG_COINS_IN_USE, 16'd32768, 1'b0, 16'd0,     16'd0}
    };

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_amount     = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [FIELD_W-1:0] m_coin_count;
    logic [FIELD_W-1:0] m_leftover;
    logic               cfg_wr_en    = 1'b0;
    cfg_idx_t           cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Local copy of the register file.
    logic [COINS_USE_W-1:0] coins_sel;
    logic [FIELD_W-1:0]     coin_val [NUM_COIN_REGS];

    change_t pending_change [$];
    int      error_count        = 0;
    int      sender_idle_pct    = 0;
    int      receiver_stall_pct = 0;

    greedy_coin_change_counter #(
        .MAX_COINS   (MAX_COINS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_amount     (s_amount),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coin_count (m_coin_count),
        .m_leftover   (m_leftover),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Greedy change for one amount under the current register copy.
    function automatic change_t greedy_change(input logic [FIELD_W-1:0] amount);
        logic [FIELD_W-1:0] den [NUM_COIN_REGS];
        logic [FIELD_W-1:0] swap;
        int unsigned used;
        int unsigned remaining;
        int unsigned count;
        int unsigned quot;
        change_t     res;
        used = (coins_sel > MAX_COINS) ? MAX_COINS : coins_sel;
        for (int i = 0; i < NUM_COIN_REGS; i++) begin
            den[i] = coin_val[i];
        end
        for (int i = 0; i + 1 < used; i++) begin
            for (int j = i + 1; j < used; j++) begin
                if (den[j] > den[i]) begin
                    swap   = den[i];
                    den[i] = den[j];
                    den[j] = swap;
                end
            end
        end
        remaining = amount & ((1 << AMOUNT_BITS) - 1);
        count     = 0;
        for (int i = 0; i < used; i++) begin
            if (den[i] != 0 && den[i] <= remaining) begin
                quot      = remaining / den[i];
                count     = count + quot;
                remaining = remaining - quot * den[i];
            end
        end
        res.coin_count = (count > 16'hFFFF) ? 16'hFFFF : count[FIELD_W-1:0];
        res.leftover   = (remaining > 16'hFFFF) ? 16'hFFFF : remaining[FIELD_W-1:0];
        return res;
    endfunction

    // One register write, mirrored into the local copy.
    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_COINS_IN_USE) begin
            coins_sel = data[COINS_USE_W-1:0];
        end else if (idx >= REG_COIN_VALUE_0 && idx < REG_COIN_VALUE_0 + NUM_COIN_REGS) begin
            if (idx - REG_COIN_VALUE_0 < MAX_COINS) begin
                coin_val[idx - REG_COIN_VALUE_0] = data[FIELD_W-1:0];
            end
        end
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic wait_block_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_change.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Send one amount after a random gap and record what should come back.
    task automatic send_amount(input logic [FIELD_W-1:0] amount, input logic typed,
                               input change_t typed_change);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            gap++;
        end
        s_valid  <= 1'b1;
        s_amount <= amount;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_change.push_back(typed ? typed_change : greedy_change(amount));
    endtask

    // Random denominations and count, with the occasional unknown register.
    task automatic program_random_setting();
        logic [FIELD_W-1:0]     val;
        logic [FIELD_W-1:0]     prev;
        logic [COINS_USE_W-1:0] sel;
        int                     kind;
        prev = COIN_VALUE_RESET;
        for (int k = 0; k < NUM_COIN_REGS; k++) begin
            kind = $urandom_range(9);
            case (kind)
                0: begin
                    val = 16'd1;
                end
                1: begin
                    val = 16'd0;
                end
                2, 3, 4, 5: begin
                    val = 16'($urandom_range(50, 2));
                end
                6, 7: begin
                    val = 16'($urandom_range(2000, 51));
                end
                8: begin
                    val = 16'($urandom);
                end
                default: begin
                    val = prev;
                end
            endcase
            cfg_write(cfg_idx_t'(REG_COIN_VALUE_0 + k), val);
            prev = val;
        end
        if ($urandom_range(9) < 8) begin
            sel = COINS_USE_W'($urandom_range(4, 1));
        end else begin
            sel = COINS_USE_W'($urandom_range(7));
        end
        cfg_write(REG_COINS_IN_USE, {13'($urandom), sel});
        if ($urandom_range(3) == 0) begin
            cfg_write(cfg_idx_t'(REG_SPARE_5 + $urandom_range(2)), 16'($urandom));
        end
    endtask

    function automatic logic [FIELD_W-1:0] pick_amount();
        int kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            return 16'($urandom);
        end else if (kind < 8) begin
            return 16'($urandom_range(200));
        end else if (kind == 8) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(15));
    endfunction

    // Result side: random stalls and the check against the oldest expectation.
    always @(posedge aclk) begin
        change_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_change.size() == 0) begin
                report_mismatch($sformatf("word with nothing expected: count %0d left %0d",
                                          m_coin_count, m_leftover));
            end else begin
                want = pending_change.pop_front();
                if (m_coin_count !== want.coin_count) begin
                    report_mismatch($sformatf("coin_count %0d, expected %0d",
                                              m_coin_count, want.coin_count));
                end
                if (m_leftover !== want.leftover) begin
                    report_mismatch($sformatf("leftover %0d, expected %0d",
                                              m_leftover, want.leftover));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        change_t typed_change;
        coins_sel = COINS_IN_USE_RESET;
        for (int k = 0; k < NUM_COIN_REGS; k++) begin
            coin_val[k] = COIN_VALUE_RESET;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                wait_block_idle();
                cfg_write(directed_rows[r].index, directed_rows[r].value);
            end else begin
                typed_change.coin_count = directed_rows[r].exp_count;
                typed_change.leftover   = directed_rows[r].exp_left;
                send_amount(directed_rows[r].value, directed_rows[r].typed, typed_change);
            end
        end

        typed_change = '0;
        for (int p = 0; p < PHASES; p++) begin
            wait_block_idle();
            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 56;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 56;
                end
                default: begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            program_random_setting();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once in the run the sender holds off until all words are back.
                if (p == 5 && n == PHASE_ITEMS / 2) begin
                    wait_block_idle();
                end
                send_amount(pick_amount(), 1'b0, typed_change);
            end
        end

        wait_block_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_greedy_coin_change_counter: PASS");
        end else begin
            $display("tb_greedy_coin_change_counter: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #LIMIT_NS;
        $display("tb_greedy_coin_change_counter: FAIL");
        $finish;
    end

endmodule

// ===== greedy_coin_change_counter.f =====
rtl/gcc_pkg.sv
rtl/gcc_cfg_regs.sv
rtl/gcc_serial_div.sv
rtl/greedy_coin_change_counter.sv
bench/tb_greedy_coin_change_counter.sv
